/* hw/rtl/rcpc_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// RC PWM pulse capture package
// Shared widths, reset values, codes and types of the pulse capture block.
// ============================================================================
package rcpc_pkg;

    localparam int ACTION_W       = 2;
    localparam int CHAN_W         = 3;
    localparam int RAW_W          = 27;
    localparam int SCALED_W       = 17;
    localparam int MID_W          = 16;
    localparam int SMAX_W         = 16;
    localparam int PERIOD_W       = 27;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 27;
    localparam int MAX_COUNT_BITS = 32;
    localparam int NUM_TRIMS      = 3;

    localparam int DEF_NUM_CHANNELS = 6;
    localparam int DEF_COUNT_BITS   = 27;

    localparam logic [MID_W-1:0]           MIDSCALE_RST   = 16'd1500;
    localparam logic signed [SCALED_W-1:0] SCALED_MIN_RST = -17'sd500;
    localparam logic [SMAX_W-1:0]          SCALED_MAX_RST = 16'd500;
    localparam logic [CHAN_W-1:0]          LAST_CHAN_RST  = 3'd4;
    localparam logic [PERIOD_W-1:0]        PERIOD_RST     = 27'd100000000;
    localparam logic [RAW_W-1:0]           TRIM_RST       = RAW_W'(MIDSCALE_RST);

    // Channels that own a trim slot: aileron, elevator and rudder.
    localparam logic [CHAN_W-1:0] CH_AILERON = 3'd1;
    localparam logic [CHAN_W-1:0] CH_RUDDER  = 3'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_EDGE    = 2'd1,
        ACT_READ    = 2'd2,
        ACT_CAPTURE = 2'd3
    } action_t;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MIDSCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALED_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALED_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CHAN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd4;

    typedef struct packed {
        logic                      kind;
        logic [CHAN_W-1:0]         chan;
        logic [MAX_COUNT_BITS-1:0] width;
        logic [RAW_W-1:0]          trim;
    } result_t;

    typedef struct packed {
        logic [MID_W-1:0]           midscale;
        logic signed [SCALED_W-1:0] scaled_min;
        logic [SMAX_W-1:0]          scaled_max;
    } scale_cfg_t;

endpackage

/* hw/rtl/rcpc_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// RC PWM pulse capture channels
// Valid/ready channels for input items, result items and register writes.
// ============================================================================
interface pulse_in_if;
    logic                           valid;
    logic                           ready;
    logic [rcpc_pkg::ACTION_W-1:0]  action;
    logic [rcpc_pkg::CHAN_W-1:0]    channel;

    modport source (output valid, output action, output channel, input ready);
    modport sink (input valid, input action, input channel, output ready);
endinterface

interface pulse_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 result_kind;
    logic [rcpc_pkg::CHAN_W-1:0]          chan_out;
    logic [rcpc_pkg::RAW_W-1:0]           raw_width_us;
    logic signed [rcpc_pkg::SCALED_W-1:0] scaled_value;
    logic [rcpc_pkg::RAW_W-1:0]           trim_value_us;

    modport source (output valid, output result_kind, output chan_out,
                    output raw_width_us, output scaled_value, output trim_value_us,
                    input ready);
    modport sink (input valid, input result_kind, input chan_out,
                  input raw_width_us, input scaled_value, input trim_value_us,
                  output ready);
endinterface

interface cfg_wr_if;
    logic                             valid;
    logic                             ready;
    logic [rcpc_pkg::CFG_IDX_W-1:0]   index;
    logic [rcpc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/rc_pwm_multichannel_pulse_capture.sv */
`timescale 1ns / 1ps
// ============================================================================
// RC PWM multichannel pulse capture
// Measures receiver pulse widths per channel against a microsecond counter.
// ============================================================================
// Usage:
// Items arrive on item_in: a microsecond tick, an edge on a channel, a read of
// a channel, or a capture of the aileron, elevator and rudder trims. Results
// leave on result_out: a frame-complete item after the closing edge of the
// configured last channel, and a reply to every read. Registers are written on
// cfg, which is always ready; write them only while no item is in flight.
// The block takes one item every cycle while item_in.ready is high. An
// accepted item moves from the registered reads of the start and width
// memories through the update stage into the scaling stage, and from there
// the scaled and clamped values are loaded into the output register that
// offers the result on result_out.
// Edge items read the memories on acceptance and write them in the update
// stage, and a forwarding register covers an entry written by the previous
// item. When the receiver stalls, the output register holds its item and the
// item behind it waits in the scaling stage; only when both are full does
// item_in.ready drop, and the whole pipeline freezes until result_out.ready.
// Reset clears the counter and the per-channel open and width-known flags and
// sets the registers and the trims to their reset values at once; there is no
// clearing pass, and a channel whose width was never written reads as zero.
// ============================================================================
module rc_pwm_multichannel_pulse_capture #(
    parameter int NUM_CHANNELS = rcpc_pkg::DEF_NUM_CHANNELS,
    parameter int COUNT_BITS   = rcpc_pkg::DEF_COUNT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    pulse_in_if.sink    item_in,
    pulse_out_if.source result_out,
    cfg_wr_if.sink      cfg
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = COUNT_BITS;
    localparam int WW = ((CW > rcpc_pkg::PERIOD_W) ? CW : rcpc_pkg::PERIOD_W) + 1;

    // Configuration registers.
    logic [rcpc_pkg::MID_W-1:0]           midscale_reg;
    logic signed [rcpc_pkg::SCALED_W-1:0] scaled_min_reg;
    logic [rcpc_pkg::SMAX_W-1:0]          scaled_max_reg;
    logic [rcpc_pkg::CHAN_W-1:0]          last_chan_reg;
    logic [rcpc_pkg::PERIOD_W-1:0]        period_reg;

    // Pipeline handshake.
    logic in_fire;
    logic adv;
    logic exec;

    // Update stage: the item whose memory reads are arriving.
    logic                        s1_valid_reg;
    rcpc_pkg::action_t           s1_action_reg;
    logic [rcpc_pkg::CHAN_W-1:0] s1_chan_reg;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               s1_addr;
    logic                        in_range;
    logic                        width_known;
    logic                        is_trim_chan;
    logic [1:0]                  tidx;

    logic [CW-1:0] start_rd;
    logic [CW-1:0] width_rd;
    logic [CW-1:0] start_q;
    logic [CW-1:0] width_q;
    logic [CW-1:0] new_w;
    logic          wrap;
    logic [WW-1:0] span;
    logic [WW-1:0] tick_sum;
    logic          tick_wrap;

    logic [CW-1:0]           counter_reg;
    logic [CW-1:0]           counter_next;
    logic [NUM_CHANNELS-1:0] await_reg;
    logic [NUM_CHANNELS-1:0] await_next;
    logic [NUM_CHANNELS-1:0] wvalid_reg;
    logic [NUM_CHANNELS-1:0] wvalid_next;

    logic [rcpc_pkg::RAW_W-1:0] trim_reg   [rcpc_pkg::NUM_TRIMS];
    logic [rcpc_pkg::RAW_W-1:0] trim_next  [rcpc_pkg::NUM_TRIMS];
    logic [rcpc_pkg::RAW_W-1:0] mirror_reg [rcpc_pkg::NUM_TRIMS];
    logic [rcpc_pkg::RAW_W-1:0] mirror_next[rcpc_pkg::NUM_TRIMS];
    logic [rcpc_pkg::RAW_W-1:0] trim_sel;

    logic start_we;
    logic width_we;

    // Forwarding of the last executed item's memory writes.
    logic          sfwd_valid_reg;
    logic [AW-1:0] sfwd_addr_reg;
    logic [CW-1:0] sfwd_data_reg;
    logic          wfwd_valid_reg;
    logic [AW-1:0] wfwd_addr_reg;
    logic [CW-1:0] wfwd_data_reg;

    rcpc_pkg::result_t    res;
    logic                 res_valid;
    rcpc_pkg::scale_cfg_t scale_cfg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midscale_reg   <= rcpc_pkg::MIDSCALE_RST;
            scaled_min_reg <= rcpc_pkg::SCALED_MIN_RST;
            scaled_max_reg <= rcpc_pkg::SCALED_MAX_RST;
            last_chan_reg  <= rcpc_pkg::LAST_CHAN_RST;
            period_reg     <= rcpc_pkg::PERIOD_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                rcpc_pkg::REG_MIDSCALE:
                    midscale_reg <= cfg.data[rcpc_pkg::MID_W-1:0];
                rcpc_pkg::REG_SCALED_MIN:
                    scaled_min_reg <= $signed(cfg.data[rcpc_pkg::SCALED_W-1:0]);
                rcpc_pkg::REG_SCALED_MAX:
                    scaled_max_reg <= cfg.data[rcpc_pkg::SMAX_W-1:0];
                rcpc_pkg::REG_LAST_CHAN:
                    last_chan_reg <= cfg.data[rcpc_pkg::CHAN_W-1:0];
                rcpc_pkg::REG_PERIOD:
                    period_reg <= cfg.data[rcpc_pkg::PERIOD_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // The whole pipeline moves together whenever the result stage can take an item.
    assign item_in.ready = adv;
    assign in_fire       = item_in.valid && adv;
    assign exec          = s1_valid_reg && adv;

    assign rd_addr = AW'(item_in.channel);
    assign s1_addr = AW'(s1_chan_reg);

    rcpc_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_CHANNELS)
    ) u_start_ram (
        .clk     (clk),
        .wr_en   (start_we),
        .wr_addr (s1_addr),
        .wr_data (counter_reg),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (start_rd)
    );

    rcpc_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_CHANNELS)
    ) u_width_ram (
        .clk     (clk),
        .wr_en   (width_we),
        .wr_addr (s1_addr),
        .wr_data (new_w),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (width_rd)
    );

    // Memory data, with the previous item's write taking precedence.
    always_comb
    begin
        in_range     = 32'(s1_chan_reg) < 32'(NUM_CHANNELS);
        width_known  = in_range && wvalid_reg[s1_addr];
        is_trim_chan = (s1_chan_reg >= rcpc_pkg::CH_AILERON) &&
                       (s1_chan_reg <= rcpc_pkg::CH_RUDDER);
        tidx         = 2'(s1_chan_reg - rcpc_pkg::CH_AILERON);
        trim_sel     = is_trim_chan ? trim_reg[tidx] : rcpc_pkg::RAW_W'(midscale_reg);

        if (sfwd_valid_reg && (sfwd_addr_reg == s1_addr))
        begin
            start_q = sfwd_data_reg;
        end
        else
        begin
            start_q = start_rd;
        end

        if (!width_known)
        begin
            width_q = '0;
        end
        else if (wfwd_valid_reg && (wfwd_addr_reg == s1_addr))
        begin
            width_q = wfwd_data_reg;
        end
        else
        begin
            width_q = width_rd;
        end

        // A pulse that spans a counter wrap gets one period added back.
        wrap  = counter_reg < start_q;
        span  = WW'(counter_reg) + (wrap ? WW'(period_reg) : WW'(0)) - WW'(start_q);
        new_w = span[CW-1:0];

        tick_sum  = WW'(counter_reg) + WW'(1);
        tick_wrap = tick_sum >= WW'(period_reg);
    end

    always_comb
    begin
        counter_next = counter_reg;
        await_next   = await_reg;
        wvalid_next  = wvalid_reg;
        trim_next    = trim_reg;
        mirror_next  = mirror_reg;
        start_we     = 1'b0;
        width_we     = 1'b0;
        res_valid    = 1'b0;
        res.kind     = rcpc_pkg::KIND_READ;
        res.chan     = s1_chan_reg;
        res.width    = rcpc_pkg::MAX_COUNT_BITS'(width_q);
        res.trim     = trim_sel;

        if (exec)
        begin
            case (s1_action_reg)
                rcpc_pkg::ACT_TICK:
                begin
                    counter_next = tick_wrap ? '0 : tick_sum[CW-1:0];
                end
                rcpc_pkg::ACT_EDGE:
                begin
                    // Edges on channels that do not exist are dropped.
                    if (in_range)
                    begin
                        if (!await_reg[s1_addr])
                        begin
                            await_next[s1_addr] = 1'b1;
                            start_we            = 1'b1;
                        end
                        else
                        begin
                            await_next[s1_addr]  = 1'b0;
                            width_we             = 1'b1;
                            wvalid_next[s1_addr] = 1'b1;
                            if (is_trim_chan)
                            begin
                                mirror_next[tidx] = rcpc_pkg::RAW_W'(new_w);
                            end
                            if (s1_chan_reg == last_chan_reg)
                            begin
                                counter_next = '0;
                                res_valid    = 1'b1;
                                res.kind     = rcpc_pkg::KIND_FRAME;
                                res.width    = rcpc_pkg::MAX_COUNT_BITS'(new_w);
                            end
                        end
                    end
                end
                rcpc_pkg::ACT_READ:
                begin
                    res_valid = 1'b1;
                end
                rcpc_pkg::ACT_CAPTURE:
                begin
                    // The mirror holds the latest aileron, elevator and rudder widths.
                    trim_next = mirror_reg;
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s1_action_reg  <= rcpc_pkg::ACT_TICK;
            s1_chan_reg    <= '0;
            counter_reg    <= '0;
            await_reg      <= '0;
            wvalid_reg     <= '0;
            sfwd_valid_reg <= 1'b0;
            sfwd_addr_reg  <= '0;
            sfwd_data_reg  <= '0;
            wfwd_valid_reg <= 1'b0;
            wfwd_addr_reg  <= '0;
            wfwd_data_reg  <= '0;
            for (int i = 0; i < rcpc_pkg::NUM_TRIMS; i++)
            begin
                trim_reg[i]   <= rcpc_pkg::TRIM_RST;
                mirror_reg[i] <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= in_fire;
            end
            if (in_fire)
            begin
                s1_action_reg <= rcpc_pkg::action_t'(item_in.action);
                s1_chan_reg   <= item_in.channel;
            end
            counter_reg <= counter_next;
            await_reg   <= await_next;
            wvalid_reg  <= wvalid_next;
            trim_reg    <= trim_next;
            mirror_reg  <= mirror_next;
            if (exec)
            begin
                sfwd_valid_reg <= start_we;
                sfwd_addr_reg  <= s1_addr;
                sfwd_data_reg  <= counter_reg;
                wfwd_valid_reg <= width_we;
                wfwd_addr_reg  <= s1_addr;
                wfwd_data_reg  <= new_w;
            end
        end
    end

    assign scale_cfg.midscale   = midscale_reg;
    assign scale_cfg.scaled_min = scaled_min_reg;
    assign scale_cfg.scaled_max = scaled_max_reg;

    rcpc_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .cfg        (scale_cfg),
        .take       (adv),
        .result_out (result_out)
    );

endmodule

/* hw/rtl/rcpc_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module rcpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read and a write to the same entry in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/rcpc_scale.sv */
`timescale 1ns / 1ps
// ============================================================================
// RC PWM pulse capture result stage
// Scales and clamps the width of a result and holds it in the output register.
// ============================================================================
module rcpc_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  rcpc_pkg::result_t    res,
    input  rcpc_pkg::scale_cfg_t cfg,
    output logic                 take,
    pulse_out_if.source          result_out
);

    localparam int DW = rcpc_pkg::MAX_COUNT_BITS + 2;

    logic                       s2_valid_reg;
    rcpc_pkg::result_t          s2_reg;
    logic                       out_valid_reg;
    logic                       out_kind_reg;
    logic [rcpc_pkg::CHAN_W-1:0] out_chan_reg;
    logic [rcpc_pkg::RAW_W-1:0] out_raw_reg;
    logic signed [rcpc_pkg::SCALED_W-1:0] out_scaled_reg;
    logic [rcpc_pkg::RAW_W-1:0] out_trim_reg;

    logic                 out_load;
    logic signed [DW-1:0] w_s;
    logic signed [DW-1:0] mid_s;
    logic signed [DW-1:0] lo_s;
    logic signed [DW-1:0] hi_s;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] clamped;

    assign out_load = !out_valid_reg || result_out.ready;
    assign take     = !s2_valid_reg || out_load;

    // Lower limit tested first; if inverted, below it clamps low, else high.
    always_comb
    begin
        w_s   = $signed(DW'(s2_reg.width));
        mid_s = $signed(DW'(cfg.midscale));
        lo_s  = DW'(cfg.scaled_min);
        hi_s  = $signed(DW'(cfg.scaled_max));
        diff  = w_s - mid_s;
        if (diff < lo_s)
        begin
            clamped = lo_s;
        end
        else if (diff > hi_s)
        begin
            clamped = hi_s;
        end
        else
        begin
            clamped = diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s2_valid_reg <= res_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            s2_reg <= res;
        end
        if (out_load && s2_valid_reg)
        begin
            out_kind_reg   <= s2_reg.kind;
            out_chan_reg   <= s2_reg.chan;
            out_raw_reg    <= s2_reg.width[rcpc_pkg::RAW_W-1:0];
            out_scaled_reg <= clamped[rcpc_pkg::SCALED_W-1:0];
            out_trim_reg   <= s2_reg.trim;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.result_kind   = out_kind_reg;
    assign result_out.chan_out      = out_chan_reg;
    assign result_out.raw_width_us  = out_raw_reg;
    assign result_out.scaled_value  = out_scaled_reg;
    assign result_out.trim_value_us = out_trim_reg;

endmodule

/* hw/rtl/rcpc_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// RC PWM pulse capture checker
// Port-level checks of result ordering and output stability.
// ============================================================================
module rcpc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic [rcpc_pkg::ACTION_W-1:0]        in_action,
    input logic [rcpc_pkg::CHAN_W-1:0]          in_channel,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 out_kind,
    input logic [rcpc_pkg::CHAN_W-1:0]          out_chan,
    input logic [rcpc_pkg::RAW_W-1:0]           out_raw,
    input logic signed [rcpc_pkg::SCALED_W-1:0] out_scaled,
    input logic [rcpc_pkg::RAW_W-1:0]           out_trim
);

    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item withdrawn while stalled");

    // A stalled result item keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_chan) &&
            $stable(out_raw) && $stable(out_scaled) && $stable(out_trim))
        else $error("result payload changed while stalled");

    // With the receiver ready while the item passes, a read is answered in order with a read reply for its channel.
    a_read_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_action == rcpc_pkg::ACT_READ)) ##1 out_ready ##1 out_ready
        |=> out_valid && (out_kind == rcpc_pkg::KIND_READ) &&
            (out_chan == $past(in_channel, 3)))
        else $error("read item not answered in order");

    // Ticks and captures never produce a result item.
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && ((in_action == rcpc_pkg::ACT_TICK) ||
                     (in_action == rcpc_pkg::ACT_CAPTURE)))
        ##1 out_ready ##1 out_ready |=> !out_valid)
        else $error("result item produced by a tick or capture");

endmodule

bind rc_pwm_multichannel_pulse_capture rcpc_checker u_rcpc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item_in.valid),
    .in_ready   (item_in.ready),
    .in_action  (item_in.action),
    .in_channel (item_in.channel),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_kind   (result_out.result_kind),
    .out_chan   (result_out.chan_out),
    .out_raw    (result_out.raw_width_us),
    .out_scaled (result_out.scaled_value),
    .out_trim   (result_out.trim_value_us)
);
